/* hdl/tgfw_pkg.sv */
// ----------------------------------------------------------------------------
// tgfw_pkg
// Shared types, constants and the glyph font for the text sheet writer.
// ----------------------------------------------------------------------------
package tgfw_pkg;

	localparam int DefSheetDim = 60;
	localparam int GlyphRows   = 5;
	localparam int GlyphPitch  = 6;
	localparam int GlyphCols   = GlyphPitch - 1;

	localparam logic [7:0] DOT_CHAR   = 8'd46;
	localparam logic [7:0] INK_CHAR   = 8'd42;
	localparam logic [7:0] SPACE_CHAR = 8'd32;
	localparam logic [7:0] CODE_A     = 8'd65;
	localparam logic [7:0] CODE_Z     = 8'd90;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		AL_COLUMN = 2'd0,
		AL_LEFT   = 2'd1,
		AL_RIGHT  = 2'd2,
		AL_CENTER = 2'd3
	} align_t;

	// Kind of work queued for the back end
	typedef enum logic [1:0] {
		JOB_CLEAR = 2'd0,
		JOB_CELL  = 2'd1,
		JOB_GLYPH = 2'd2,
		JOB_READ  = 2'd3
	} job_kind_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_CLEAR = 2'd1,
		BK_GLYPH = 2'd2,
		BK_READ  = 2'd3
	} bk_state_t;

	// Row is unsigned. The column is signed 11 bits: far placements wrap, but
	// every wrapped value is still negative or well past the sheet edge.
	typedef struct packed {
		job_kind_t   kind;
		logic [9:0]  row;
		logic [10:0] col;
		logic [7:0]  code;
	} job_t;

	// One glyph row, bit 4 is the leftmost column
	function automatic logic [4:0] glyph_bits(input logic [4:0] letter, input logic [2:0] r);
		logic [24:0] g;
		begin
			case (letter)
				5'd0:    g = {5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11};
				5'd1:    g = {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E};
				5'd2:    g = {5'h0F, 5'h11, 5'h10, 5'h10, 5'h0F};
				5'd3:    g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
				5'd4:    g = {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F};
				5'd5:    g = {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10};
				5'd6:    g = {5'h0F, 5'h10, 5'h13, 5'h11, 5'h0E};
				5'd7:    g = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
				5'd8:    g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F};
				5'd9:    g = {5'h07, 5'h02, 5'h02, 5'h12, 5'h0C};
				5'd10:   g = {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11};
				5'd11:   g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
				5'd12:   g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
				5'd13:   g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
				5'd14:   g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
				5'd15:   g = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
				5'd16:   g = {5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F};
				5'd17:   g = {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11};
				5'd18:   g = {5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
				5'd19:   g = {5'h1F, 5'h15, 5'h04, 5'h04, 5'h0E};
				5'd20:   g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
				5'd21:   g = {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
				5'd22:   g = {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
				5'd23:   g = {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
				5'd24:   g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04};
				5'd25:   g = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
				default: g = '0;
			endcase
			case (r)
				3'd0:    glyph_bits = g[24:20];
				3'd1:    glyph_bits = g[19:15];
				3'd2:    glyph_bits = g[14:10];
				3'd3:    glyph_bits = g[9:5];
				3'd4:    glyph_bits = g[4:0];
				default: glyph_bits = '0;
			endcase
		end
	endfunction

endpackage

/* hdl/text_glyph_framebuffer_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_glyph_framebuffer_writer_unit
// Text sheet writer with a 5x5 A-Z glyph font and a sheet memory with one write and one read port.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The front registers it
// and a short queue holds it until the back end is free, so busy is high
// while a job sits in the front register or waits in the queue. The back end
// writes a single cell as it takes the job; a read, a glyph sweep over its
// 5x5 pixels and a clear go through their own state afterwards, and clear
// sweeps all SHEET_DIM*SHEET_DIM cells one cell per cycle. The same sweep runs
// after reset; busy stays low during it until an item is taken, and that first
// item then waits in the queue. With the back end idle, a taken read passes the
// front register, the queue, the read state and the output registers, and
// cell_char with its one-cycle done strobe cannot be held off. A new item can
// be taken while the back end still works, and it then waits in the queue.
module text_glyph_framebuffer_writer_unit #(
	parameter int SHEET_DIM = tgfw_pkg::DefSheetDim
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic       font_large,
	input  logic [1:0] align_mode,
	input  logic [5:0] row,
	input  logic [5:0] column,
	input  logic [7:0] text_len,
	input  logic [7:0] char_index,
	input  logic [7:0] char_code,
	output logic       done,
	output logic [7:0] cell_char
);
	import tgfw_pkg::*;

	logic in_acc, fr_valid, q_ne, q_af, pop, busy_back;
	job_t fr_job, q_head;

	assign in_acc = start && !busy;
	// Hold off while a job sits in the front register or the queue has one
	assign busy = fr_valid || q_af || (busy_back && q_ne);

	tgfw_front #(.SHEET_DIM(SHEET_DIM)) u_front (
		.clk, .arst_n, .in_valid(in_acc), .opcode, .font_large, .align_mode,
		.row, .column, .text_len, .char_index, .char_code,
		.job_valid(fr_valid), .job(fr_job)
	);

	tgfw_queue u_queue (
		.clk, .arst_n, .push(fr_valid), .push_job(fr_job), .pop,
		.not_empty(q_ne), .almost_full(q_af), .head(q_head)
	);

	tgfw_back #(.SHEET_DIM(SHEET_DIM)) u_back (
		.clk, .arst_n, .job_avail(q_ne), .job(q_head), .job_pop(pop),
		.busy_back, .done, .cell_char
	);

endmodule

/* hdl/tgfw_front.sv */
// ----------------------------------------------------------------------------
// tgfw_front
// Accepts items, filters NOP items and no-op draws and computes the start column.
// ----------------------------------------------------------------------------
module tgfw_front #(
	parameter int SHEET_DIM = tgfw_pkg::DefSheetDim
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       opcode,
	input  logic             font_large,
	input  logic [1:0]       align_mode,
	input  logic [5:0]       row,
	input  logic [5:0]       column,
	input  logic [7:0]       text_len,
	input  logic [7:0]       char_index,
	input  logic [7:0]       char_code,
	output logic             job_valid,
	output tgfw_pkg::job_t   job
);
	import tgfw_pkg::*;

	localparam logic signed [11:0] Dim    = 12'(SHEET_DIM);
	localparam logic signed [11:0] Half   = 12'(SHEET_DIM / 2);
	localparam logic signed [11:0] HalfLo = 12'(SHEET_DIM / 2 - GlyphPitch / 2);
	localparam logic signed [11:0] Pitch  = 12'(GlyphPitch);

	logic signed [11:0] idx_s, len_s, col_s, rem_s, half_len_s, col_c;
	logic               act;
	job_kind_t          kind_c;

	// Column placement; multiplies by 6 are shift-adds on narrow values
	always_comb begin
		idx_s      = {4'd0, char_index};
		len_s      = {4'd0, text_len};
		col_s      = {6'd0, column};
		rem_s      = len_s - 12'sd1 - idx_s;
		half_len_s = {5'd0, text_len[7:1]};
		col_c      = '0;
		if (!font_large) begin
			case (align_mode)
				AL_COLUMN: col_c = col_s + idx_s;
				AL_LEFT:   col_c = idx_s;
				AL_RIGHT:  col_c = Dim - 12'sd1 - rem_s;
				AL_CENTER: col_c = Half - half_len_s + idx_s;
				default:   col_c = '0;
			endcase
		end else begin
			case (align_mode)
				AL_COLUMN: col_c = col_s + Pitch * idx_s;
				AL_LEFT:   col_c = Pitch * idx_s;
				AL_RIGHT:  col_c = Dim - Pitch - Pitch * rem_s;
				AL_CENTER: col_c = (text_len[0] ? HalfLo : Half) - Pitch * half_len_s
						+ Pitch * idx_s;
				default:   col_c = '0;
			endcase
		end
	end

	// Classify the item
	always_comb begin
		act    = 1'b0;
		kind_c = JOB_CLEAR;
		case (op_t'(opcode))
			OP_CLEAR: begin
				act = 1'b1;
				kind_c = JOB_CLEAR;
			end
			OP_READ: begin
				act = 1'b1;
				kind_c = JOB_READ;
			end
			OP_DRAW: begin
				if (char_index < text_len) begin
					if (font_large) begin
						act = (char_code >= CODE_A) && (char_code <= CODE_Z);
						kind_c = JOB_GLYPH;
					end else begin
						act = (char_code != SPACE_CHAR);
						kind_c = JOB_CELL;
					end
				end
			end
			default: act = 1'b0;
		endcase
	end

	// Registered job toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
		end else begin
			job_valid <= in_valid && act;
		end
	end

	always_ff @(posedge clk) begin
		job.kind <= kind_c;
		job.row  <= {4'd0, row};
		job.col  <= (kind_c == JOB_READ) ? {5'd0, column} : col_c[10:0];
		job.code <= char_code;
	end

endmodule

/* hdl/tgfw_queue.sv */
// ----------------------------------------------------------------------------
// tgfw_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module tgfw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tgfw_pkg::job_t push_job,
	input  logic           pop,
	output logic           not_empty,
	output logic           almost_full,
	output tgfw_pkg::job_t head
);
	import tgfw_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

	assign head        = mem_q[rp_q];
	assign not_empty   = (cnt_q != 2'd0);
	assign almost_full = (cnt_q != 2'd0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == 2'd2))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && cnt_q == 2'd0))
		else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("queue count out of range");

endmodule

/* hdl/tgfw_back.sv */
// ----------------------------------------------------------------------------
// tgfw_back
// Carries out jobs on the sheet memory, one cell per cycle.
// ----------------------------------------------------------------------------
module tgfw_back #(
	parameter int SHEET_DIM = tgfw_pkg::DefSheetDim
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_avail,
	input  tgfw_pkg::job_t job,
	output logic           job_pop,
	output logic           busy_back,
	output logic           done,
	output logic [7:0]     cell_char
);
	import tgfw_pkg::*;

	localparam int Cells = SHEET_DIM * SHEET_DIM;
	localparam int AW    = $clog2(Cells);
	localparam int DW    = $clog2(SHEET_DIM);

	logic [7:0]    mem [Cells];
	bk_state_t     st_q, st_d;
	logic [AW-1:0] addr_q;
	logic [2:0]    gr_q;
	logic [2:0]    gc_q;
	logic [9:0]    row_q;
	logic [10:0]   col_q;
	logic [4:0]    letter_q;
	logic          rd_off_q;
	logic [7:0]    rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          load;
	logic          glyph_last;
	logic [4:0]    bits;
	logic [10:0]   pr, pc;
	logic          on_sheet;
	logic          cell_on;

	function automatic logic [AW-1:0] lin(input logic [DW-1:0] r, input logic [DW-1:0] c);
		lin = AW'(r * SHEET_DIM + c);
	endfunction

	// Pixel coordinate during a glyph sweep
	always_comb begin
		bits       = glyph_bits(letter_q, gr_q);
		pr         = {1'b0, row_q} + 11'(gr_q);
		pc         = col_q + 11'(gc_q);
		on_sheet   = !pc[10] && (pc < 11'(SHEET_DIM)) && (pr < 11'(SHEET_DIM));
		glyph_last = (gr_q == 3'(GlyphRows - 1)) && (gc_q == 3'(GlyphCols - 1));
		cell_on    = !job.col[10] && (job.col < 11'(SHEET_DIM))
				&& (job.row < 10'(SHEET_DIM));
	end

	// Sequencer next state and memory port control
	always_comb begin
		st_d  = st_q;
		load  = 1'b0;
		we    = 1'b0;
		waddr = '0;
		wdata = DOT_CHAR;
		case (st_q)
			BK_IDLE: begin
				if (job_avail) begin
					load = 1'b1;
					case (job.kind)
						JOB_CLEAR: st_d = BK_CLEAR;
						JOB_GLYPH: st_d = BK_GLYPH;
						JOB_READ:  st_d = BK_READ;
						JOB_CELL: begin
							we    = cell_on;
							waddr = lin(DW'(job.row), DW'(job.col));
							wdata = job.code;
						end
						default: st_d = BK_IDLE;
					endcase
				end
			end
			BK_CLEAR: begin
				we    = 1'b1;
				waddr = addr_q;
				wdata = DOT_CHAR;
				if (addr_q == AW'(Cells - 1)) st_d = BK_IDLE;
			end
			BK_GLYPH: begin
				we    = on_sheet && bits[3'(GlyphCols - 1) - gc_q];
				waddr = lin(DW'(pr), DW'(pc));
				wdata = INK_CHAR;
				if (glyph_last) st_d = BK_IDLE;
			end
			BK_READ: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_CLEAR;
			addr_q <= '0;
			gr_q   <= '0;
			gc_q   <= '0;
			done   <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == BK_READ);
			if (load) begin
				addr_q <= '0;
				gr_q   <= '0;
				gc_q   <= '0;
			end else if (st_q == BK_CLEAR) begin
				addr_q <= addr_q + 1'b1;
			end else if (st_q == BK_GLYPH) begin
				if (gc_q == 3'(GlyphCols - 1)) begin
					gc_q <= '0;
					gr_q <= gr_q + 3'd1;
				end else begin
					gc_q <= gc_q + 3'd1;
				end
			end
		end
	end

	// Job payload latch
	always_ff @(posedge clk) begin
		if (load) begin
			row_q    <= job.row;
			col_q    <= job.col;
			letter_q <= 5'(job.code - CODE_A);
			rd_off_q <= !cell_on;
		end
	end

	// Sheet memory with one write port and one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[lin(DW'(row_q), DW'(col_q))];
	end

	assign job_pop   = load;
	assign busy_back = (st_q != BK_IDLE);
	assign cell_char = rd_off_q ? 8'd0 : rd_q;

	a_glyph_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_GLYPH && glyph_last) |=> st_q == BK_IDLE)
		else $error("glyph sweep overran");
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_READ) |=> done)
		else $error("read lost");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (st_q == BK_IDLE && job_avail))
		else $error("pop while busy");

endmodule

/* tb/text_glyph_framebuffer_writer_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_glyph_framebuffer_writer_unit_checker
// Shadows the character sheet, predicts every read and checks cell_char.
// ----------------------------------------------------------------------------
module text_glyph_framebuffer_writer_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] opcode,
	input  logic       font_large,
	input  logic [1:0] align_mode,
	input  logic [5:0] row,
	input  logic [5:0] column,
	input  logic [7:0] text_len,
	input  logic [7:0] char_index,
	input  logic [7:0] char_code,
	input  logic       done,
	input  logic [7:0] cell_char,
	output int         fail_count,
	output int         reads_pending
);
	import tgfw_pkg::*;

	localparam int Dim = DefSheetDim;

	logic [7:0] sheet_model [Dim*Dim];
	logic [7:0] read_values [$];

	// Font table of our own, bit 4 leftmost
	logic [4:0] font_rows [26][5] = '{
		'{5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, '{5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
		'{5'h0F, 5'h11, 5'h10, 5'h10, 5'h0F}, '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E},
		'{5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F}, '{5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10},
		'{5'h0F, 5'h10, 5'h13, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
		'{5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F}, '{5'h07, 5'h02, 5'h02, 5'h12, 5'h0C},
		'{5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, '{5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
		'{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F}, '{5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
		'{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}, '{5'h1F, 5'h15, 5'h04, 5'h04, 5'h0E},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
		'{5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, '{5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
		'{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, '{5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F}
	};

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic void plot(input int r, input int c, input logic [7:0] v);
		if (r >= 0 && r < Dim && c >= 0 && c < Dim)
			sheet_model[r*Dim + c] = v;
	endfunction

	// Apply one accepted item to the shadow sheet
	task automatic apply_item(input op_t op, input logic big, input align_t al,
			input int r, input int c, input int n, input int i, input logic [7:0] ch);
		int x;
		logic [4:0] bits;
		case (op)
			OP_CLEAR: foreach (sheet_model[k]) sheet_model[k] = DOT_CHAR;
			OP_READ: begin
				if (r < Dim && c < Dim)
					read_values.push_back(sheet_model[r*Dim + c]);
				else
					read_values.push_back(8'd0);
			end
			OP_DRAW: begin
				if (i < n) begin
					if (!big) begin
						case (al)
							AL_COLUMN: x = c + i;
							AL_LEFT:   x = i;
							AL_RIGHT:  x = Dim - 1 - (n - 1 - i);
							default:   x = Dim/2 - n/2 + i;
						endcase
						if (ch != SPACE_CHAR)
							plot(r, x, ch);
					end else if (ch >= CODE_A && ch <= CODE_Z) begin
						case (al)
							AL_COLUMN: x = c + GlyphPitch*i;
							AL_LEFT:   x = GlyphPitch*i;
							AL_RIGHT:  x = Dim - GlyphPitch - GlyphPitch*(n - 1 - i);
							default:   x = ((n % 2) ? Dim/2 - GlyphPitch/2 : Dim/2)
								- GlyphPitch*(n/2) + GlyphPitch*i;
						endcase
						for (int gr = 0; gr < GlyphRows; gr++) begin
							bits = font_rows[ch - CODE_A][gr];
							for (int gc = 0; gc < GlyphCols; gc++)
								if (bits[4-gc])
									plot(r + gr, x + gc, INK_CHAR);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	initial begin
		fail_count = 0;
		foreach (sheet_model[k]) sheet_model[k] = DOT_CHAR;
	end

	assign reads_pending = read_values.size();

	// Results first, then the item taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (read_values.size() == 0)
					report_mismatch($sformatf("unexpected result %0d", cell_char));
				else if (cell_char !== read_values[0]) begin
					report_mismatch($sformatf("cell_char %0d, expected %0d",
						cell_char, read_values[0]));
					void'(read_values.pop_front());
				end else
					void'(read_values.pop_front());
			end
			if (start && !busy)
				apply_item(op_t'(opcode), font_large, align_t'(align_mode), row, column,
					text_len, char_index, char_code);
		end
	end

endmodule

/* tb/text_glyph_framebuffer_writer_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_glyph_framebuffer_writer_unit_test
// Drives clears, draws and reads at random pace; the checker judges reads.
// ----------------------------------------------------------------------------
module text_glyph_framebuffer_writer_unit_test;
	import tgfw_pkg::*;

	localparam int WatchLimit = 20000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy, done;
	logic [1:0] opcode = OP_NOP;
	logic       font_large = 1'b0;
	logic [1:0] align_mode = AL_COLUMN;
	logic [5:0] row = '0, column = '0;
	logic [7:0] text_len = 8'd1, char_index = '0, char_code = '0;
	logic [7:0] cell_char;
	int         fail_count, reads_pending;
	int         idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_glyph_framebuffer_writer_unit dut (.*);
	text_glyph_framebuffer_writer_unit_checker sheet_checker (.*);

	// Watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Present one item and hold it until taken
	task automatic issue(input op_t op, input logic big, input align_t al,
			input int r, input int c, input int n, input int i, input int ch);
		start      <= 1'b1;
		opcode     <= op;
		font_large <= big;
		align_mode <= al;
		row        <= 6'(r);
		column     <= 6'(c);
		text_len   <= 8'(n);
		char_index <= 8'(i);
		char_code  <= 8'(ch);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic random_read();
		issue(OP_READ, 1'($urandom), align_t'($urandom), $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(1, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
	endtask

	// Up to 14 characters of a string with random placement; some indices and codes are left random
	task automatic random_string();
		int n, r, c;
		logic big;
		align_t al;
		n   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
		big = 1'($urandom);
		al  = align_t'($urandom);
		r   = $urandom_range(0, 63);
		c   = $urandom_range(0, 63);
		for (int i = 0; i < n && i < 14; i++)
			issue(OP_DRAW, big, al, r, c, n, ($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 255) : i, ($urandom_range(0, 5) == 0) ?
				$urandom_range(0, 255) : $urandom_range(CODE_A, CODE_Z));
	endtask

	initial begin
		int burst;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every align mode, both fonts, clipping, special cases
		issue(OP_DRAW, 1'b1, AL_COLUMN, 0, 0, 1, 0, CODE_A);
		issue(OP_READ, 0, AL_COLUMN, 0, 1, 1, 0, 0);
		issue(OP_DRAW, 1'b1, AL_COLUMN, 59, 58, 255, 0, CODE_Z);
		issue(OP_DRAW, 1'b1, AL_RIGHT, 10, 0, 255, 0, "M");
		issue(OP_DRAW, 1'b1, AL_RIGHT, 10, 0, 3, 2, "W");
		issue(OP_DRAW, 1'b1, AL_CENTER, 20, 0, 5, 0, "H");
		issue(OP_DRAW, 1'b1, AL_CENTER, 20, 0, 4, 3, "Q");
		issue(OP_DRAW, 1'b1, AL_LEFT, 30, 0, 20, 9, "S");
		issue(OP_DRAW, 1'b1, AL_LEFT, 40, 0, 2, 0, "a");
		issue(OP_DRAW, 1'b0, AL_COLUMN, 63, 63, 255, 254, 8'hFF);
		issue(OP_DRAW, 1'b0, AL_RIGHT, 5, 0, 255, 1, "x");
		issue(OP_DRAW, 1'b0, AL_RIGHT, 5, 0, 4, 3, "y");
		issue(OP_DRAW, 1'b0, AL_CENTER, 5, 0, 7, 2, "z");
		issue(OP_DRAW, 1'b0, AL_LEFT, 5, 0, 3, 3, "q");
		issue(OP_DRAW, 1'b0, AL_LEFT, 0, 1, 2, 1, SPACE_CHAR);
		issue(OP_NOP, 1'b1, AL_CENTER, 0, 0, 1, 0, "A");
		issue(OP_READ, 0, AL_COLUMN, 5, 59, 1, 0, 0);
		issue(OP_READ, 0, AL_COLUMN, 5, 30, 1, 0, 0);
		issue(OP_READ, 0, AL_COLUMN, 12, 56, 1, 0, 0);
		issue(OP_READ, 0, AL_COLUMN, 60, 0, 1, 0, 0);
		issue(OP_READ, 0, AL_COLUMN, 0, 63, 1, 0, 0);
		issue(OP_CLEAR, 0, AL_COLUMN, 0, 0, 1, 0, 0);
		issue(OP_READ, 0, AL_COLUMN, 0, 1, 1, 0, 0);

		// Hold off until every read has come back
		start <= 1'b0;
		while (reads_pending != 0) @(posedge clk);

		// Random: strings with reads mixed in, rare clears, bursty pacing
		for (int k = 0; k < 36; k++) begin
			burst = $urandom_range(1, 4);
			for (int b = 0; b < burst; b++) begin
				case ($urandom_range(0, 19))
					0:       issue(OP_CLEAR, 1'($urandom), align_t'($urandom), 0, 0, 1, 0, 0);
					1, 2:    issue(OP_NOP, 1'($urandom), align_t'($urandom),
						$urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(1, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
					3, 4, 5, 6, 7: random_read();
					default: random_string();
				endcase
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 40));
		end

		start <= 1'b0;
		while (reads_pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
